>>> rtl/bpk_pkg.sv
package bpk_pkg;

  // CPU table geometry
  localparam int unsigned NUM_CPUS   = 16;
  localparam int unsigned CPU_IDX_W  = $clog2(NUM_CPUS);
  localparam int unsigned CPU_CNT_W  = 5;
  localparam int unsigned LOAD_W     = 17;
  localparam int unsigned SUM_W      = LOAD_W + 1;
  localparam int unsigned CHOSEN_W   = 4;

  // 1.0 with 16 fraction bits (Q1.16 loads, Q2.16 sums)
  localparam logic [SUM_W-1:0]  ONE_SUM  = SUM_W'(65536);
  localparam logic [LOAD_W-1:0] ONE_LOAD = LOAD_W'(65536);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEURISTIC_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_COUNT      = 1'b1;

  typedef enum logic [1:0] {
    MODE_BEST_FIT  = 2'd0,
    MODE_WORST_FIT = 2'd1,
    MODE_FIRST_FIT = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  // Sequencer to fit unit
  typedef struct packed {
    logic clear;
    logic step;
  } fit_ctrl_t;

  // Fit unit to sequencer
  typedef struct packed {
    logic take;
    logic found;
  } fit_stat_t;

endpackage

>>> rtl/bpk_load_table.sv
module bpk_load_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic [bpk_pkg::CPU_IDX_W-1:0] rd_idx_i,
  output logic [bpk_pkg::LOAD_W-1:0]    rd_load_o,
  input  logic                          wr_en_i,
  input  logic [bpk_pkg::CPU_IDX_W-1:0] wr_idx_i,
  input  logic [bpk_pkg::LOAD_W-1:0]    wr_load_i
);
  import bpk_pkg::*;

  logic [NUM_CPUS-1:0] valid_q, valid_d;
  logic [LOAD_W-1:0]   load_q [NUM_CPUS];

  // Valid bits: a cleared entry reads as zero load
  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = '0;
    end else if (wr_en_i) begin
      valid_d[wr_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (wr_en_i && !clear_i) begin
      load_q[wr_idx_i] <= wr_load_i;
    end
  end

  assign rd_load_o = valid_q[rd_idx_i] ? load_q[rd_idx_i] : '0;

endmodule

>>> rtl/bpk_fit_unit.sv
module bpk_fit_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpk_pkg::fit_ctrl_t            ctrl_i,
  input  logic [1:0]                    mode_i,
  input  logic [bpk_pkg::LOAD_W-1:0]    task_load_i,
  input  logic [bpk_pkg::LOAD_W-1:0]    cpu_load_i,
  input  logic [bpk_pkg::CPU_IDX_W-1:0] cpu_idx_i,
  output bpk_pkg::fit_stat_t            stat_o,
  output logic [bpk_pkg::CPU_IDX_W-1:0] pick_o,
  output logic [bpk_pkg::LOAD_W-1:0]    pick_load_o
);
  import bpk_pkg::*;

  logic                 found_q;
  logic [LOAD_W-1:0]    best_q;
  logic [CPU_IDX_W-1:0] pick_q;
  logic [LOAD_W-1:0]    new_load_q;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  space_w;
  logic [LOAD_W-1:0] space;
  logic              fits;
  logic              take;

  // One candidate per cycle while step is set: new load, remaining space, keep-or-drop
  always_comb begin
    sum     = {1'b0, cpu_load_i} + {1'b0, task_load_i};
    fits    = (sum <= ONE_SUM);
    space_w = ONE_SUM - sum;
    space   = space_w[LOAD_W-1:0];
    case (mode_i)
      MODE_BEST_FIT:  take = fits && (space < (found_q ? best_q : ONE_LOAD));
      MODE_WORST_FIT: take = fits && (!found_q || (space > best_q));
      MODE_FIRST_FIT: take = (sum < ONE_SUM);
      default:        take = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctrl_i.step && take) begin
      found_q <= 1'b1;
    end
  end

  // Best candidate so far
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && take && !ctrl_i.clear) begin
      best_q     <= space;
      pick_q     <= cpu_idx_i;
      new_load_q <= sum[LOAD_W-1:0];
    end
  end

  assign stat_o.take  = ctrl_i.step && take;
  assign stat_o.found = found_q;
  assign pick_o       = pick_q;
  assign pick_load_o  = new_load_q;

endmodule

>>> rtl/task_to_cpu_bin_packer_core.sv
// An accepted task is scanned by the shared fit unit over CPUs 0 to n-1, where n
// is the saturated CPU count; the result is registered in the done state.
// First fit stops at the first CPU whose load stays below 1.0; a failed set skips
// the scan. New tasks are accepted only in idle, once the last result is registered.
// Reset: asynchronous, active low; clears loads, failure flag, mode (best fit)
// and sets the CPU count to one.
module task_to_cpu_bin_packer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpk_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bpk_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             task_valid_i,
  output logic                             task_ready_o,
  input  logic [bpk_pkg::LOAD_W-1:0]       task_load_i,
  input  logic                             first_of_set_i,
  output logic                             result_valid_o,
  input  logic                             result_ready_i,
  output logic [bpk_pkg::CHOSEN_W-1:0]     chosen_cpu_o,
  output logic                             placed_ok_o
);
  import bpk_pkg::*;

  state_e               state_q, state_d;
  logic [1:0]           mode_q;
  logic [CPU_CNT_W-1:0] cpu_count_q;
  logic                 set_failed_q, set_failed_d;
  logic [LOAD_W-1:0]    task_q;
  logic [CPU_IDX_W-1:0] idx_q, idx_d;
  logic [CPU_IDX_W-1:0] last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  logic [CHOSEN_W-1:0]  out_cpu_q;
  logic                 out_ok_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 skip;
  logic [CPU_CNT_W-1:0] n_sat;
  logic [CPU_CNT_W-1:0] n_m1;
  logic                 table_clear;
  logic                 table_we;
  logic [LOAD_W-1:0]    rd_load;
  logic [CPU_IDX_W-1:0] pick;
  logic [LOAD_W-1:0]    pick_load;
  fit_ctrl_t            fit_ctrl;
  fit_stat_t            fit_stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_BEST_FIT;
      cpu_count_q <= CPU_CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEURISTIC_MODE: mode_q      <= cfg_wdata_i[1:0];
        CFG_CPU_COUNT:      cpu_count_q <= cfg_wdata_i;
        default:            ;
      endcase
    end
  end

  // Effective CPU count and scan bound
  always_comb begin
    n_sat = (cpu_count_q > CPU_CNT_W'(NUM_CPUS)) ? CPU_CNT_W'(NUM_CPUS) : cpu_count_q;
    n_m1  = n_sat - CPU_CNT_W'(1);
  end

  assign in_fire     = task_valid_i && task_ready_o;
  assign out_free    = !out_valid_q || result_ready_i;
  assign table_clear = in_fire && first_of_set_i;

  // Sequencer: next state and controls
  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    last_d         = last_q;
    set_failed_d   = set_failed_q;
    out_valid_d    = out_valid_q && !result_ready_i;
    task_ready_o   = 1'b0;
    fit_ctrl.clear = 1'b0;
    fit_ctrl.step  = 1'b0;
    table_we       = 1'b0;
    skip           = (!first_of_set_i && set_failed_q) || (cpu_count_q == '0) ||
                     !((mode_q == MODE_BEST_FIT) || (mode_q == MODE_WORST_FIT) ||
                       (mode_q == MODE_FIRST_FIT));
    case (state_q)
      ST_IDLE: begin
        task_ready_o = 1'b1;
        if (task_valid_i) begin
          fit_ctrl.clear = 1'b1;
          idx_d          = '0;
          last_d         = n_m1[CPU_IDX_W-1:0];
          if (first_of_set_i) begin
            set_failed_d = 1'b0;
          end
          state_d = skip ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        fit_ctrl.step = 1'b1;
        if ((fit_stat.take && (mode_q == MODE_FIRST_FIT)) || (idx_q == last_q)) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + CPU_IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          table_we    = fit_stat.found;
          if (!fit_stat.found) begin
            set_failed_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      set_failed_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      last_q       <= '0;
    end else begin
      state_q      <= state_d;
      set_failed_q <= set_failed_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
      last_q       <= last_d;
    end
  end

  // Task and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      task_q <= task_load_i;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_cpu_q <= fit_stat.found ? CHOSEN_W'(pick) : '0;
      out_ok_q  <= fit_stat.found;
    end
  end

  bpk_load_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (table_clear),
    .rd_idx_i  (idx_q),
    .rd_load_o (rd_load),
    .wr_en_i   (table_we),
    .wr_idx_i  (pick),
    .wr_load_i (pick_load)
  );

  bpk_fit_unit u_fit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fit_ctrl),
    .mode_i      (mode_q),
    .task_load_i (task_q),
    .cpu_load_i  (rd_load),
    .cpu_idx_i   (idx_q),
    .stat_o      (fit_stat),
    .pick_o      (pick),
    .pick_load_o (pick_load)
  );

  assign result_valid_o = out_valid_q;
  assign chosen_cpu_o   = out_cpu_q;
  assign placed_ok_o    = out_ok_q;

`ifndef NO_ASSERTIONS
  // A new result only comes out of the completion step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

  // The scan never runs past the last CPU in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= last_q))
    else $error("scan index beyond CPU count");

  // A chosen CPU always lies within the scanned range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && fit_stat.found |-> (pick <= last_q))
    else $error("pick outside scanned CPUs");

  // A placed result cannot stand beside a failed set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |-> !set_failed_q)
    else $error("placement reported in failed set");
`endif

endmodule
